### hw/rtl/spci_pkg.sv
// Shared types, character codes and reply codes for the serial PWM command interpreter.
package spci_pkg;

    localparam int LINE_BYTES  = 32;
    localparam int COUNT_W     = $clog2(LINE_BYTES);
    localparam int MAX_COUNT   = LINE_BYTES - 1;

    typedef logic [7:0]         t_byte;
    typedef logic [15:0]        t_period;
    typedef logic [2:0]         t_code;
    typedef logic [16:0]        t_compare;
    typedef logic [6:0]         t_duty;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [22:0]        t_prod;

    localparam t_period PERIOD_RESET = 16'd999;

    // Reply codes.
    localparam t_code RC_STARTED = 3'd0;
    localparam t_code RC_STOPPED = 3'd1;
    localparam t_code RC_DUTY    = 3'd2;
    localparam t_code RC_INVALID = 3'd3;
    localparam t_code RC_RUNNING = 3'd4;
    localparam t_code RC_UNKNOWN = 3'd5;

    // Command candidates, one bit each.
    localparam int CAND_ON     = 0;
    localparam int CAND_OFF    = 1;
    localparam int CAND_PWM    = 2;
    localparam int CAND_STATUS = 3;

    // Number parser phases.
    localparam logic [1:0] NUM_PRE    = 2'd0;
    localparam logic [1:0] NUM_SIGN   = 2'd1;
    localparam logic [1:0] NUM_DIGITS = 2'd2;
    localparam logic [1:0] NUM_DONE   = 2'd3;

    localparam t_byte CH_CR    = 8'd13;
    localparam t_byte CH_LF    = 8'd10;
    localparam t_byte CH_NUL   = 8'd0;
    localparam t_byte CH_SPACE = 8'd32;
    localparam t_byte CH_TAB   = 8'd9;
    localparam t_byte CH_VT    = 8'd11;
    localparam t_byte CH_FF    = 8'd12;
    localparam t_byte CH_PLUS  = 8'd43;
    localparam t_byte CH_MINUS = 8'd45;
    localparam t_byte CH_ZERO  = 8'd48;
    localparam t_byte CH_NINE  = 8'd57;

    localparam logic [6:0] DUTY_MAX = 7'd100;

    // Division by 100 as a multiply by ceil(2^30 / 100); exact for products below 2^23.
    localparam int          RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100   = 24'd10737419;

    // True when character c matches position i of command word k.
    function automatic logic f_word_hit(input logic [1:0] k, input t_count i, input t_byte c);
        t_byte exp_c;
        logic  in_len;
        exp_c  = 8'd0;
        in_len = 1'b0;
        case (k)
            2'(CAND_ON): begin
                in_len = (i < t_count'(2));
                case (i)
                    t_count'(0): exp_c = "O";
                    t_count'(1): exp_c = "N";
                    default:     exp_c = 8'd0;
                endcase
            end
            2'(CAND_OFF): begin
                in_len = (i < t_count'(3));
                case (i)
                    t_count'(0): exp_c = "O";
                    t_count'(1): exp_c = "F";
                    t_count'(2): exp_c = "F";
                    default:     exp_c = 8'd0;
                endcase
            end
            2'(CAND_PWM): begin
                in_len = (i < t_count'(4));
                case (i)
                    t_count'(0): exp_c = "P";
                    t_count'(1): exp_c = "W";
                    t_count'(2): exp_c = "M";
                    t_count'(3): exp_c = "=";
                    default:     exp_c = 8'd0;
                endcase
            end
            default: begin
                in_len = (i < t_count'(6));
                case (i)
                    t_count'(0): exp_c = "S";
                    t_count'(1): exp_c = "T";
                    t_count'(2): exp_c = "A";
                    t_count'(3): exp_c = "T";
                    t_count'(4): exp_c = "U";
                    t_count'(5): exp_c = "S";
                    default:     exp_c = 8'd0;
                endcase
            end
        endcase
        return in_len && (c == exp_c);
    endfunction

endpackage

### hw/rtl/serial_pwm_command_interpreter.sv
// Line assembler and command interpreter that turns serial text into PWM control replies.
// Accepts one word per cycle while o_ready is high; a line end's reply enters the reply stage.
// Each word updates the line matcher in the cycle it is accepted; the duty product is
// registered with the reply, and the divide by 100 is a reciprocal multiply in the output stage.
// A reply stage and the output register form a two-word queue; input stalls only while both hold
// a word and the output is stalled. Synchronous active-low reset: period_top returns to 999,
// PWM stopped, compare value zero.
module serial_pwm_command_interpreter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  spci_pkg::t_byte     i_rx_byte,
    input  logic                i_cfg_we,
    input  spci_pkg::t_period   i_cfg_wdata,
    output logic                o_valid,
    input  logic                i_ready,
    output spci_pkg::t_code     o_reply_code,
    output logic                o_pwm_enabled,
    output spci_pkg::t_compare  o_compare_out,
    output spci_pkg::t_duty     o_duty_percent
);
    import spci_pkg::*;

    t_period    r_period;
    t_count     r_count,    n_count;
    t_count     r_mlen,     n_mlen;
    logic [3:0] r_cand,     n_cand;
    logic [1:0] r_phase,    n_phase;
    logic       r_neg,      n_neg;
    t_duty      r_accum,    n_accum;
    logic       r_over,     n_over;
    logic       r_text_end, n_text_end;
    logic       r_running,  n_running;
    t_compare   r_cmp_held;

    logic       r_s1_valid;
    t_code      r_s1_code;
    logic       r_s1_running;
    t_duty      r_s1_duty;
    t_prod      r_s1_prod;

    logic       r_o_valid;
    t_code      r_o_code;
    logic       r_o_running;
    t_compare   r_o_compare;
    t_duty      r_o_duty;

    logic       w_in_acc;
    logic       w_out_free;
    logic       w_s1_move;
    logic       w_term;
    logic       w_digit;
    logic [3:0] w_digit_val;
    logic [9:0] w_next_val;
    logic       w_res_fire;
    t_code      w_res_code;
    t_duty      w_res_duty;
    t_prod      w_prod;
    logic [46:0] w_scaled;
    t_compare   w_quot;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_ready    = !r_s1_valid || w_out_free;
    assign w_in_acc   = i_valid && o_ready;

    assign w_term      = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign w_digit     = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign w_digit_val = 4'(i_rx_byte - CH_ZERO);
    assign w_next_val  = 10'(r_accum) * 10'd10 + 10'(w_digit_val);

    assign w_prod = t_prod'(r_accum) * t_prod'({1'b0, r_period} + 17'd1);

    always_comb begin
        n_count    = r_count;
        n_mlen     = r_mlen;
        n_cand     = r_cand;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_accum    = r_accum;
        n_over     = r_over;
        n_text_end = r_text_end;
        n_running  = r_running;
        w_res_fire = 1'b0;
        w_res_code = RC_UNKNOWN;
        w_res_duty = '0;

        if (w_in_acc) begin
            if (!w_term) begin
                if (r_count < t_count'(MAX_COUNT)) begin
                    n_count = r_count + t_count'(1);
                    if (!r_text_end) begin
                        if (i_rx_byte == CH_NUL) begin
                            n_text_end = 1'b1;
                        end else begin
                            n_mlen = r_mlen + t_count'(1);
                            if (r_cand[CAND_ON]
                                    && !f_word_hit(2'(CAND_ON), r_mlen, i_rx_byte)) begin
                                n_cand[CAND_ON] = 1'b0;
                            end
                            if (r_cand[CAND_OFF]
                                    && !f_word_hit(2'(CAND_OFF), r_mlen, i_rx_byte)) begin
                                n_cand[CAND_OFF] = 1'b0;
                            end
                            if (r_cand[CAND_STATUS]
                                    && !f_word_hit(2'(CAND_STATUS), r_mlen, i_rx_byte)) begin
                                n_cand[CAND_STATUS] = 1'b0;
                            end
                            if (r_cand[CAND_PWM]) begin
                                if (r_mlen >= t_count'(4)) begin
                                    if (r_phase == NUM_PRE) begin
                                        if (i_rx_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF}) begin
                                            n_phase = NUM_PRE;
                                        end else if (i_rx_byte == CH_PLUS) begin
                                            n_phase = NUM_SIGN;
                                        end else if (i_rx_byte == CH_MINUS) begin
                                            n_neg   = 1'b1;
                                            n_phase = NUM_SIGN;
                                        end else if (w_digit) begin
                                            n_phase = NUM_DIGITS;
                                        end else begin
                                            n_phase = NUM_DONE;
                                        end
                                    end else if (r_phase != NUM_DONE) begin
                                        n_phase = w_digit ? NUM_DIGITS : NUM_DONE;
                                    end
                                    if (w_digit && r_phase != NUM_DONE && !r_over) begin
                                        if (w_next_val > 10'(DUTY_MAX)) begin
                                            n_over = 1'b1;
                                        end else begin
                                            n_accum = 7'(w_next_val);
                                        end
                                    end
                                end else if (!f_word_hit(2'(CAND_PWM), r_mlen, i_rx_byte)) begin
                                    n_cand[CAND_PWM] = 1'b0;
                                end
                            end
                        end
                    end
                end
            end else if (r_count != '0) begin
                w_res_fire = 1'b1;
                if (r_cand[CAND_ON] && r_mlen == t_count'(2)) begin
                    n_running  = 1'b1;
                    w_res_code = RC_STARTED;
                end else if (r_cand[CAND_OFF] && r_mlen == t_count'(3)) begin
                    n_running  = 1'b0;
                    w_res_code = RC_STOPPED;
                end else if (r_cand[CAND_PWM] && r_mlen >= t_count'(4)) begin
                    if (r_over || (r_neg && r_accum != '0)) begin
                        w_res_code = RC_INVALID;
                    end else begin
                        w_res_code = RC_DUTY;
                        w_res_duty = r_accum;
                    end
                end else if (r_cand[CAND_STATUS] && r_mlen == t_count'(6)) begin
                    w_res_code = RC_RUNNING;
                end else begin
                    w_res_code = RC_UNKNOWN;
                end
                n_count    = '0;
                n_mlen     = '0;
                n_cand     = '1;
                n_phase    = NUM_PRE;
                n_neg      = 1'b0;
                n_accum    = '0;
                n_over     = 1'b0;
                n_text_end = 1'b0;
            end
        end
    end

    assign w_scaled = 47'(r_s1_prod) * 47'(RECIP_100);
    assign w_quot   = w_scaled[RECIP_SHIFT +: 17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_count    <= '0;
            r_mlen     <= '0;
            r_cand     <= '1;
            r_phase    <= NUM_PRE;
            r_neg      <= 1'b0;
            r_accum    <= '0;
            r_over     <= 1'b0;
            r_text_end <= 1'b0;
            r_running  <= 1'b0;
            r_cmp_held <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            r_count    <= n_count;
            r_mlen     <= n_mlen;
            r_cand     <= n_cand;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_accum    <= n_accum;
            r_over     <= n_over;
            r_text_end <= n_text_end;
            r_running  <= n_running;
            if (!r_s1_valid || w_s1_move) begin
                r_s1_valid <= w_in_acc && w_res_fire;
            end
            if (w_out_free) begin
                r_o_valid <= r_s1_valid;
            end
            if (w_s1_move && r_s1_code == RC_DUTY) begin
                r_cmp_held <= w_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_res_fire) begin
            r_s1_code    <= w_res_code;
            r_s1_running <= n_running;
            r_s1_duty    <= w_res_duty;
            r_s1_prod    <= w_prod;
        end
        if (w_s1_move) begin
            r_o_code    <= r_s1_code;
            r_o_running <= r_s1_running;
            r_o_duty    <= r_s1_duty;
            r_o_compare <= (r_s1_code == RC_DUTY) ? w_quot : r_cmp_held;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_reply_code   = r_o_code;
    assign o_pwm_enabled  = r_o_running;
    assign o_compare_out  = r_o_compare;
    assign o_duty_percent = r_o_duty;

endmodule

### dv/spci_checker.sv
// Checker for the serial PWM command interpreter: predicts each reply word and compares it.
module spci_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  spci_pkg::t_byte    i_rx_byte,
    input  logic               i_cfg_we,
    input  spci_pkg::t_period  i_cfg_wdata,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  spci_pkg::t_code    i_reply_code,
    input  logic               i_pwm_enabled,
    input  spci_pkg::t_compare i_compare_out,
    input  spci_pkg::t_duty    i_duty_percent,
    output int                 o_fail_count,
    output int                 o_pending
);
    import spci_pkg::*;

    typedef struct packed {
        t_code    code;
        logic     en;
        t_compare cmp;
        t_duty    duty;
    } t_reply;

    t_reply     reply_q[$];
    int         fails = 0;

    t_period    period_top;
    int         line_len;
    logic [3:0] cand;
    logic [1:0] num_phase;
    logic       num_neg;
    int         duty_acc;
    logic       num_over;
    int         match_len;
    logic       text_end;
    logic       pwm_on;
    t_compare   cmp_held;

    function automatic int word_len(input int k);
        case (k)
            CAND_ON:  return 2;
            CAND_OFF: return 3;
            CAND_PWM: return 4;
            default:  return 6;
        endcase
    endfunction

    function automatic t_byte word_char(input int k, input int i);
        logic [47:0] txt;
        case (k)
            CAND_ON:  txt = "ON";
            CAND_OFF: txt = "OFF";
            CAND_PWM: txt = "PWM=";
            default:  txt = "STATUS";
        endcase
        return txt[8*(word_len(k)-1-i) +: 8];
    endfunction

    task automatic clear_line();
        line_len = 0;
        cand = 4'hF;
        num_phase = NUM_PRE;
        num_neg = 1'b0;
        duty_acc = 0;
        num_over = 1'b0;
        match_len = 0;
        text_end = 1'b0;
    endtask

    task automatic add_digit(input t_byte c);
        int v;
        if (!num_over) begin
            v = duty_acc * 10 + int'(c - CH_ZERO);
            if (v > int'(DUTY_MAX)) begin
                num_over = 1'b1;
            end else begin
                duty_acc = v;
            end
        end
    endtask

    task automatic number_step(input t_byte c);
        logic dig;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        if (num_phase == NUM_PRE) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                num_phase = NUM_PRE;
            end else if (c == CH_PLUS) begin
                num_phase = NUM_SIGN;
            end else if (c == CH_MINUS) begin
                num_neg = 1'b1;
                num_phase = NUM_SIGN;
            end else if (dig) begin
                add_digit(c);
                num_phase = NUM_DIGITS;
            end else begin
                num_phase = NUM_DONE;
            end
        end else if (num_phase == NUM_SIGN || num_phase == NUM_DIGITS) begin
            if (dig) begin
                add_digit(c);
                num_phase = NUM_DIGITS;
            end else begin
                num_phase = NUM_DONE;
            end
        end
    endtask

    task automatic take_byte(input t_byte c);
        int     k;
        t_reply r;
        if (c != CH_CR && c != CH_LF) begin
            if (line_len < MAX_COUNT) begin
                line_len++;
                if (!text_end) begin
                    if (c == CH_NUL) begin
                        text_end = 1'b1;
                    end else begin
                        for (k = 0; k < 4; k++) begin
                            if (cand[k]) begin
                                if (k == CAND_PWM && match_len >= 4) begin
                                    number_step(c);
                                end else if (!(match_len < word_len(k) &&
                                               word_char(k, match_len) == c)) begin
                                    cand[k] = 1'b0;
                                end
                            end
                        end
                        if (match_len < 255) begin
                            match_len++;
                        end
                    end
                end
            end
        end else if (line_len != 0) begin
            r.duty = '0;
            if (cand[CAND_ON] && match_len == 2) begin
                pwm_on = 1'b1;
                r.code = RC_STARTED;
            end else if (cand[CAND_OFF] && match_len == 3) begin
                pwm_on = 1'b0;
                r.code = RC_STOPPED;
            end else if (cand[CAND_PWM] && match_len >= 4) begin
                if (num_over || (num_neg && duty_acc != 0)) begin
                    r.code = RC_INVALID;
                end else begin
                    r.duty = t_duty'(duty_acc);
                    cmp_held = t_compare'((duty_acc * (int'(period_top) + 1)) / 100);
                    r.code = RC_DUTY;
                end
            end else if (cand[CAND_STATUS] && match_len == 6) begin
                r.code = RC_RUNNING;
            end else begin
                r.code = RC_UNKNOWN;
            end
            r.en = pwm_on;
            r.cmp = cmp_held;
            reply_q.push_back(r);
            clear_line();
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            period_top = PERIOD_RESET;
            pwm_on = 1'b0;
            cmp_held = '0;
            clear_line();
            reply_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (reply_q.size() == 0) begin
                    fails++;
                    $display("%0t: reply word expected none got code %0d", $time,
                             i_reply_code);
                end else begin
                    want = reply_q.pop_front();
                    check_field("reply_code", 32'(want.code), 32'(i_reply_code));
                    check_field("pwm_enabled", 32'(want.en), 32'(i_pwm_enabled));
                    check_field("compare_out", 32'(want.cmp), 32'(i_compare_out));
                    check_field("duty_percent", 32'(want.duty), 32'(i_duty_percent));
                end
            end
            if (i_cfg_we) begin
                period_top = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                take_byte(i_rx_byte);
            end
        end
        o_pending <= reply_q.size();
        o_fail_count <= fails;
    end

endmodule

### dv/testbench.sv
// Top of the testbench: drives serial command text and settings into the interpreter.
module testbench;
    import spci_pkg::*;

    localparam int LONG_HOLD   = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 130;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_byte    i_rx_byte;
    logic     i_cfg_we;
    t_period  i_cfg_wdata;
    logic     o_valid;
    logic     i_ready;
    t_code    o_reply_code;
    logic     o_pwm_enabled;
    t_compare o_compare_out;
    t_duty    o_duty_percent;

    int       fail_count;
    int       pending;
    bit       calm = 1'b0;
    int       hold_asks = 0;
    int       sent = 0;
    t_byte    line_q[$];

    serial_pwm_command_interpreter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_reply_code   (o_reply_code),
        .o_pwm_enabled  (o_pwm_enabled),
        .o_compare_out  (o_compare_out),
        .o_duty_percent (o_duty_percent)
    );

    spci_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_reply_code   (o_reply_code),
        .i_pwm_enabled  (o_pwm_enabled),
        .i_compare_out  (o_compare_out),
        .i_duty_percent (o_duty_percent),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_byte(input t_byte b);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        while (line_q.size() != 0) begin
            send_byte(line_q.pop_front());
        end
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            line_q.push_back(t_byte'(s[i]));
        end
    endtask

    task automatic push_end();
        line_q.push_back(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_period(input t_period v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_number();
        int n;
        int mode;
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       line_q.push_back(CH_SPACE);
                1:       line_q.push_back(CH_TAB);
                2:       line_q.push_back(CH_VT);
                default: line_q.push_back(CH_FF);
            endcase
        end
        case ($urandom_range(0, 3))
            0:       line_q.push_back(CH_PLUS);
            1:       line_q.push_back(CH_MINUS);
            default: ;
        endcase
        mode = $urandom_range(0, 19);
        if (mode < 13) begin
            push_text($sformatf("%0d", $urandom_range(0, 100)));
        end else if (mode < 16) begin
            push_text($sformatf("%0d", $urandom_range(101, 99999)));
        end else if (mode < 18) begin
            push_text($sformatf("00%0d", $urandom_range(0, 100)));
        end
        if ($urandom_range(0, 4) == 0) begin
            push_text("x7");
        end
    endtask

    task automatic queue_random_line();
        int    sel;
        int    n;
        int    i;
        int    cut;
        string w;
        case ($urandom_range(0, 3))
            0:       w = "ON";
            1:       w = "OFF";
            2:       w = "PWM=";
            default: w = "STATUS";
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            push_text("ON");
        end else if (sel < 22) begin
            push_text("OFF");
        end else if (sel < 30) begin
            push_text("STATUS");
        end else if (sel < 60) begin
            push_text("PWM=");
            queue_number();
        end else if (sel < 68) begin
            cut = $urandom_range(1, w.len());
            for (i = 0; i < cut; i++) line_q.push_back(t_byte'(w[i]));
            line_q.push_back(t_byte'($urandom_range(33, 126)));
        end else if (sel < 78) begin
            n = $urandom_range(1, 10);
            repeat (n) line_q.push_back(t_byte'($urandom_range(0, 255)));
        end else if (sel < 83) begin
            if ($urandom_range(0, 1) != 0) push_text("PWM=");
            n = $urandom_range(24, 36);
            repeat (n) line_q.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_ZERO);
            line_q.push_back(t_byte'($urandom_range(33, 126)));
        end else if (sel < 88) begin
            cut = $urandom_range(0, w.len());
            for (i = 0; i < w.len(); i++) begin
                if (i == cut) line_q.push_back(CH_NUL);
                line_q.push_back(t_byte'(w[i]));
            end
            if (cut == w.len()) line_q.push_back(CH_NUL);
        end else if (sel >= 93) begin
            push_text(w);
            line_q.push_back(t_byte'($urandom_range(33, 126)));
        end
        push_end();
        send_line();
    endtask

    initial begin : receiver
        int hold_seen;
        int held;
        i_ready = 1'b0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                i_ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(negedge i_clk);
                    held++;
                end
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int      phase;
        int      mark;
        t_period v;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rx_byte = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_text("ON\r\nSTATUS\nPWM=100\rOFF\rPWM=0\n\rPWM=101\rPWM=-0\rPWM=-7\r");
        push_text("PWM=\t +42z\rPWM=999\rPWM=\rONX\rOF\rpwm=5\r");
        line_q.push_back(CH_VT);
        push_text("ON\rO");
        line_q.push_back(CH_NUL);
        push_text("N\r");
        line_q.push_back(CH_NUL);
        push_text("\r");
        line_q.push_back(8'hFF);
        push_text("\rPWM=");
        repeat (27) line_q.push_back(CH_SPACE);
        push_text("5\r");
        send_line();

        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0:       v = 16'hFFFF;
                1:       v = 16'h0000;
                2:       v = PERIOD_RESET;
                default: v = t_period'($urandom_range(0, 65535));
            endcase
            write_period(v);
            if (phase == 1) begin
                hold_asks++;
                repeat (12) begin
                    push_text("ON\rPWM=50\n");
                    send_line();
                end
            end
            if (phase == 5) begin
                calm = 1'b1;
            end
            mark = sent;
            while (sent - mark < PHASE_BYTES) begin
                queue_random_line();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
